// ===== rtl/core/cfla_pkg.sv =====
package cfla_pkg;

  // Request opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Cell tags: zero is free, 1..TAG_LAST are live types
  localparam logic [2:0] TAG_FREE = 3'd0;
  localparam logic [2:0] TAG_LAST = 3'd3;

  typedef enum logic [2:0] {
    STATUS_OK           = 3'd0,
    STATUS_BAD_TYPE     = 3'd1,
    STATUS_EMPTY        = 3'd2,
    STATUS_RANGE        = 3'd3,
    STATUS_ALREADY_FREE = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR = 2'd0,
    S_IDLE  = 2'd1,
    S_EXEC  = 2'd2
  } ctrl_state_e;

  // Controller -> datapath
  typedef struct packed {
    logic sweep;   // write one reset entry, advance sweep counter
    logic accept;  // latch request, launch memory read
    logic commit;  // apply request, load result register
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic sweep_last;
    logic out_ready;
  } sts_t;

endpackage

// ===== rtl/core/cell_free_list_allocator_top.sv =====
// Channel | Direction | Handshake              | Payload
// --------+-----------+------------------------+---------------------------------------------
// in      | input     | in_valid_i/in_stall_o  | op_i, cell_type_i, release_index_i
// out     | output    | out_valid_o/out_stall_i| status_o, granted_index_o,
//         |           |                        | allocated_total_o, freed_total_o
//
// The cell memory is read at accept (list head or the named cell), and the result
// is decided and written back at commit, which waits while an earlier result is held.
// After reset a sweep writes every cell entry, building the free chain and clearing the
// tags; in_stall_o stays high for its duration.
// A result held by out_stall_i holds the next request in S_EXEC, before its commit.
module cell_free_list_allocator_top #(
  parameter int POOL_CELLS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [2:0]  cell_type_i,
  input  logic [9:0]  release_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [9:0]  granted_index_o,
  output logic [31:0] allocated_total_o,
  output logic [31:0] freed_total_o
);

  cfla_pkg::cmd_t cmd;
  cfla_pkg::sts_t sts;

  cfla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cfla_dp #(
    .POOL_CELLS (POOL_CELLS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .op_i              (op_i),
    .cell_type_i       (cell_type_i),
    .release_index_i   (release_index_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .status_o          (status_o),
    .granted_index_o   (granted_index_o),
    .allocated_total_o (allocated_total_o),
    .freed_total_o     (freed_total_o)
  );

endmodule

// ===== rtl/core/cfla_ram.sv =====
module cfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/cfla_ctrl.sv =====
module cfla_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  cfla_pkg::sts_t sts_i,
  output cfla_pkg::cmd_t cmd_o
);

  cfla_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cfla_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      cfla_pkg::S_CLEAR: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = cfla_pkg::S_IDLE;
        end
      end
      cfla_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = cfla_pkg::S_EXEC;
        end
      end
      cfla_pkg::S_EXEC: begin
        // hold here while the previous result is still pending
        if (sts_i.out_ready) begin
          cmd_o.commit = 1'b1;
          state_d      = cfla_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = cfla_pkg::S_CLEAR;
      end
    endcase
  end

endmodule

// ===== rtl/core/cfla_dp.sv =====
module cfla_dp #(
  parameter int POOL_CELLS = 1024
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cfla_pkg::cmd_t cmd_i,
  output cfla_pkg::sts_t sts_o,
  input  logic           op_i,
  input  logic [2:0]     cell_type_i,
  input  logic [9:0]     release_index_i,
  input  logic           out_stall_i,
  output logic           out_valid_o,
  output logic [2:0]     status_o,
  output logic [9:0]     granted_index_o,
  output logic [31:0]    allocated_total_o,
  output logic [31:0]    freed_total_o
);

  localparam int IDX_W   = $clog2(POOL_CELLS);
  localparam int ENTRY_W = IDX_W + 4;   // {tag, tail, link}
  localparam int EXT_W   = IDX_W + 10;

  // latched request
  logic             op_q;
  logic [2:0]       type_q;
  logic [9:0]       rel_q;

  // list state
  logic [IDX_W-1:0] head_q, head_d;
  logic             empty_q, empty_d;
  logic [31:0]      alloc_cnt_q, alloc_cnt_d;
  logic [31:0]      free_cnt_q, free_cnt_d;
  logic [IDX_W-1:0] sweep_q;

  // result register
  logic                out_valid_q, out_valid_d;
  cfla_pkg::status_e   status_q, status_d;
  logic [9:0]          granted_q, granted_d;

  // memory port
  logic               mem_we, mem_re;
  logic [IDX_W-1:0]   mem_waddr, mem_raddr;
  logic [ENTRY_W-1:0] mem_wdata, mem_rdata;

  logic [IDX_W-1:0] rd_link;
  logic             rd_tail;
  logic [2:0]       rd_tag;

  logic [EXT_W-1:0] rel_in_ext, rel_q_ext, head_ext;
  logic [IDX_W-1:0] rel_in_addr, rel_q_addr;
  logic             rel_in_range;
  cfla_pkg::status_e res_status;
  logic              res_ok;

  assign rd_link = mem_rdata[IDX_W-1:0];
  assign rd_tail = mem_rdata[IDX_W];
  assign rd_tag  = mem_rdata[IDX_W+3:IDX_W+1];

  assign rel_in_ext   = EXT_W'(release_index_i);
  assign rel_in_addr  = rel_in_ext[IDX_W-1:0];
  assign rel_q_ext    = EXT_W'(rel_q);
  assign rel_q_addr   = rel_q_ext[IDX_W-1:0];
  assign rel_in_range = rel_q_ext < EXT_W'(POOL_CELLS);
  assign head_ext     = EXT_W'(head_q);

  // decision on the latched request and the entry read at accept
  always_comb begin
    if (op_q == cfla_pkg::OP_ALLOC) begin
      if (type_q == cfla_pkg::TAG_FREE || type_q > cfla_pkg::TAG_LAST) begin
        res_status = cfla_pkg::STATUS_BAD_TYPE;
      end else if (empty_q) begin
        res_status = cfla_pkg::STATUS_EMPTY;
      end else begin
        res_status = cfla_pkg::STATUS_OK;
      end
    end else begin
      if (!rel_in_range) begin
        res_status = cfla_pkg::STATUS_RANGE;
      end else if (rd_tag == cfla_pkg::TAG_FREE) begin
        res_status = cfla_pkg::STATUS_ALREADY_FREE;
      end else begin
        res_status = cfla_pkg::STATUS_OK;
      end
    end
  end

  assign res_ok = (res_status == cfla_pkg::STATUS_OK);

  // read: head for allocate, named cell for free
  assign mem_re    = cmd_i.accept;
  assign mem_raddr = (op_i == cfla_pkg::OP_FREE) ? rel_in_addr : head_q;

  always_comb begin
    mem_we    = cmd_i.sweep | (cmd_i.commit & res_ok);
    mem_waddr = sweep_q;
    mem_wdata = {cfla_pkg::TAG_FREE, (sweep_q == '0),
                 (sweep_q == '0) ? '0 : sweep_q - IDX_W'(1)};
    if (!cmd_i.sweep) begin
      if (op_q == cfla_pkg::OP_ALLOC) begin
        // retag the head cell, keep its link
        mem_waddr = head_q;
        mem_wdata = {type_q, rd_tail, rd_link};
      end else begin
        mem_waddr = rel_q_addr;
        mem_wdata = {cfla_pkg::TAG_FREE, empty_q, empty_q ? '0 : head_q};
      end
    end
  end

  always_comb begin
    head_d      = head_q;
    empty_d     = empty_q;
    alloc_cnt_d = alloc_cnt_q;
    free_cnt_d  = free_cnt_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    granted_d   = granted_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.commit) begin
      out_valid_d = 1'b1;
      status_d    = res_status;
      granted_d   = '0;
      if (res_ok) begin
        if (op_q == cfla_pkg::OP_ALLOC) begin
          granted_d   = head_ext[9:0];
          alloc_cnt_d = alloc_cnt_q + 32'd1;
          if (rd_tail) begin
            empty_d = 1'b1;
            head_d  = '0;
          end else begin
            head_d = rd_link;
          end
        end else begin
          free_cnt_d = free_cnt_q + 32'd1;
          head_d     = rel_q_addr;
          empty_d    = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= op_i;
      type_q <= cell_type_i;
      rel_q  <= release_index_i;
    end
    status_q  <= status_d;
    granted_q <= granted_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= IDX_W'(POOL_CELLS - 1);
      empty_q     <= 1'b0;
      alloc_cnt_q <= '0;
      free_cnt_q  <= '0;
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      empty_q     <= empty_d;
      alloc_cnt_q <= alloc_cnt_d;
      free_cnt_q  <= free_cnt_d;
      out_valid_q <= out_valid_d;
      if (cmd_i.sweep) begin
        sweep_q <= sweep_q + IDX_W'(1);
      end
    end
  end

  cfla_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (POOL_CELLS)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign sts_o.sweep_last = (sweep_q == IDX_W'(POOL_CELLS - 1));
  assign sts_o.out_ready  = !out_valid_q || !out_stall_i;

  // counters only move on commit, which waits for the result slot
  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign granted_index_o   = granted_q;
  assign allocated_total_o = alloc_cnt_q;
  assign freed_total_o     = free_cnt_q;

endmodule

// ===== test/tb_cell_free_list_allocator_top.sv =====
module tb_cell_free_list_allocator_top;
  import cfla_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Full-size pool, as the block is built by default.
  localparam int POOL = 1024;
  localparam int RANDOM_PER_PHASE = 317;
  localparam int CYCLE_LIMIT = 100000;

  localparam logic [2:0] TYPE_VARIABLE    = 3'd1;
  localparam logic [2:0] TYPE_ABSTRACTION = 3'd2;
  localparam logic [2:0] TYPE_APPLICATION = 3'd3;

  typedef struct packed {
    logic       op;
    logic [2:0] kind;
    logic [9:0] idx;
    logic       typed;    // status/granted below are the expected values
    status_e    status;
    logic [9:0] granted;
  } cell_request_t;

  typedef struct packed {
    status_e     status;
    logic [9:0]  granted;
    logic [31:0] allocated;
    logic [31:0] freed;
  } grant_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        op_i;
  logic [2:0]  cell_type_i;
  logic [9:0]  release_index_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  status_o;
  logic [9:0]  granted_index_o;
  logic [31:0] allocated_total_o;
  logic [31:0] freed_total_o;

  // pool image
  logic [9:0]  next_cell [POOL];
  logic        tail_cell [POOL];
  logic [2:0]  cell_tag [POOL];
  logic [9:0]  free_head;
  logic        pool_empty;
  logic [31:0] alloc_total;
  logic [31:0] free_total;

  grant_t pending_grants [$];
  int     mismatches = 0;
  int     cycle_count = 0;
  int     send_idle_pct;
  int     recv_idle_pct;
  bit     filling;

  cell_request_t directed_rows [25] = '{
    '{OP_ALLOC, TAG_FREE,         10'd0,    1'b1, STATUS_BAD_TYPE,     10'd0},
    '{OP_ALLOC, 3'd7,             10'd1023, 1'b1, STATUS_BAD_TYPE,     10'd0},
    '{OP_ALLOC, 3'd4,             10'd0,    1'b1, STATUS_BAD_TYPE,     10'd0},
    '{OP_FREE,  3'd7,             10'd1023, 1'b1, STATUS_ALREADY_FREE, 10'd0},
    '{OP_FREE,  TYPE_VARIABLE,    10'd1000, 1'b1, STATUS_ALREADY_FREE, 10'd0},
    '{OP_FREE,  TAG_FREE,         10'd0,    1'b1, STATUS_ALREADY_FREE, 10'd0},
    '{OP_FREE,  TAG_FREE,         10'd7,    1'b1, STATUS_ALREADY_FREE, 10'd0},
    '{OP_ALLOC, TYPE_VARIABLE,    10'd1023, 1'b1, STATUS_OK,           10'd1023},
    '{OP_ALLOC, TYPE_ABSTRACTION, 10'd0,    1'b1, STATUS_OK,           10'd1022},
    '{OP_ALLOC, TYPE_APPLICATION, 10'd0,    1'b1, STATUS_OK,           10'd1021},
    '{OP_FREE,  TAG_FREE,         10'd1022, 1'b1, STATUS_OK,           10'd0},
    '{OP_FREE,  TAG_FREE,         10'd1022, 1'b1, STATUS_ALREADY_FREE, 10'd0},
    '{OP_ALLOC, TYPE_VARIABLE,    10'd0,    1'b0, STATUS_OK,           10'd0},
    '{OP_ALLOC, TYPE_ABSTRACTION, 10'd0,    1'b0, STATUS_OK,           10'd0},
    '{OP_ALLOC, TYPE_APPLICATION, 10'd0,    1'b0, STATUS_OK,           10'd0},
    '{OP_ALLOC, TYPE_VARIABLE,    10'd0,    1'b0, STATUS_OK,           10'd0},
    '{OP_ALLOC, TYPE_ABSTRACTION, 10'd0,    1'b0, STATUS_OK,           10'd0},
    '{OP_ALLOC, TYPE_APPLICATION, 10'd0,    1'b0, STATUS_OK,           10'd0},
    '{OP_ALLOC, TYPE_VARIABLE,    10'd0,    1'b0, STATUS_OK,           10'd0},
    '{OP_ALLOC, 3'd5,             10'd0,    1'b1, STATUS_BAD_TYPE,     10'd0},
    '{OP_FREE,  TAG_FREE,         10'd1021, 1'b0, STATUS_OK,           10'd0},
    '{OP_ALLOC, TYPE_APPLICATION, 10'd0,    1'b0, STATUS_OK,           10'd0},
    '{OP_FREE,  TAG_FREE,         10'd0,    1'b0, STATUS_OK,           10'd0},
    '{OP_FREE,  TAG_FREE,         10'd1023, 1'b0, STATUS_OK,           10'd0},
    '{OP_FREE,  TAG_FREE,         10'd512,  1'b1, STATUS_ALREADY_FREE, 10'd0}
  };

  cell_free_list_allocator_top #(
    .POOL_CELLS(POOL)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_i             (op_i),
    .cell_type_i      (cell_type_i),
    .release_index_i  (release_index_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .granted_index_o  (granted_index_o),
    .allocated_total_o(allocated_total_o),
    .freed_total_o    (freed_total_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  task automatic reset_pool_image();
    for (int i = 0; i < POOL; i++) begin
      cell_tag[i]  = TAG_FREE;
      tail_cell[i] = (i == 0);
      next_cell[i] = (i == 0) ? 10'd0 : 10'(i - 1);
    end
    free_head   = 10'(POOL - 1);
    pool_empty  = 1'b0;
    alloc_total = '0;
    free_total  = '0;
  endtask

  task automatic apply_to_pool(input cell_request_t rq, output grant_t res);
    int slot;
    res.status  = STATUS_OK;
    res.granted = '0;
    if (rq.op == OP_ALLOC) begin
      if (rq.kind == TAG_FREE || rq.kind > TAG_LAST) begin
        res.status = STATUS_BAD_TYPE;
      end else if (pool_empty) begin
        res.status = STATUS_EMPTY;
      end else begin
        slot = int'(free_head);
        if (tail_cell[slot]) begin
          pool_empty = 1'b1;
          free_head  = '0;
        end else begin
          free_head = next_cell[slot];
        end
        cell_tag[slot] = rq.kind;
        alloc_total    = alloc_total + 32'd1;
        res.granted    = 10'(slot);
      end
    end else begin
      slot = int'(rq.idx);
      if (slot >= POOL) begin
        res.status = STATUS_RANGE;
      end else if (cell_tag[slot] == TAG_FREE) begin
        res.status = STATUS_ALREADY_FREE;
      end else begin
        // pushing onto an empty list makes this cell the new tail
        tail_cell[slot] = pool_empty;
        next_cell[slot] = pool_empty ? 10'd0 : free_head;
        free_head       = 10'(slot);
        pool_empty      = 1'b0;
        cell_tag[slot]  = TAG_FREE;
        free_total      = free_total + 32'd1;
      end
    end
    res.allocated = alloc_total;
    res.freed     = free_total;
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  // Valid stays high from one request to the next unless a gap is taken.
  task automatic send_request(input cell_request_t rq);
    grant_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    op_i            <= rq.op;
    cell_type_i     <= rq.kind;
    release_index_i <= rq.idx;
    do @(posedge clk_i); while (in_stall_o);
    apply_to_pool(rq, res);
    if (rq.typed) begin
      res.status  = rq.status;
      res.granted = rq.granted;
    end
    pending_grants.push_back(res);
  endtask

  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_grants.size() != 0);
  endtask

  function automatic int pick_live_cell();
    int start;
    int c;
    start = $urandom_range(0, POOL - 1);
    for (int k = 0; k < POOL; k++) begin
      c = (start + k) % POOL;
      if (cell_tag[c] != TAG_FREE) return c;
    end
    return -1;
  endfunction

  // Mostly well-formed alloc/free traffic with bad types and double frees
  // mixed in.
  task automatic random_request();
    cell_request_t rq;
    int r;
    int c;
    r        = $urandom_range(0, 99);
    rq       = '0;
    rq.kind  = 3'($urandom_range(0, 7));
    rq.idx   = 10'($urandom_range(0, 1023));
    if (pool_empty) filling = 1'b0;
    else if (alloc_total == free_total) filling = 1'b1;
    else if ($urandom_range(0, 99) < 4) filling = !filling;
    if (r < 8) begin
      rq.op   = OP_ALLOC;
      rq.kind = 3'($urandom_range(0, 4));
      if (rq.kind != TAG_FREE) rq.kind = rq.kind + 3'd3;
    end else if (r < 14) begin
      rq.op  = OP_FREE;
      rq.idx = 10'($urandom_range(0, POOL - 1));
    end else if (r < 20) begin
      rq.op  = OP_FREE;
      rq.idx = 10'($urandom_range(POOL - 32, POOL - 1));
    end else if (filling ? (r < 80) : (r >= 80)) begin
      rq.op   = OP_ALLOC;
      rq.kind = 3'($urandom_range(TYPE_VARIABLE, TYPE_APPLICATION));
    end else begin
      rq.op = OP_FREE;
      c     = pick_live_cell();
      rq.idx = (c < 0) ? 10'($urandom_range(0, POOL - 1)) : 10'(c);
    end
    send_request(rq);
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin : check_results
    grant_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_grants.size() == 0) begin
        report_mismatch("result with no request pending");
      end else begin
        want = pending_grants.pop_front();
        if (status_o !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status_o, want.status));
        if (granted_index_o !== want.granted)
          report_mismatch($sformatf("granted_index %0d, expected %0d",
                                    granted_index_o, want.granted));
        if (allocated_total_o !== want.allocated)
          report_mismatch($sformatf("allocated_total %0d, expected %0d",
                                    allocated_total_o, want.allocated));
        if (freed_total_o !== want.freed)
          report_mismatch($sformatf("freed_total %0d, expected %0d",
                                    freed_total_o, want.freed));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    op_i            = OP_ALLOC;
    cell_type_i     = TAG_FREE;
    release_index_i = '0;
    filling         = 1'b1;
    send_idle_pct   = 27;
    recv_idle_pct   = 63;
    reset_pool_image();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) send_request(directed_rows[i]);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 27;
          recv_idle_pct = 63;
        end
        1: begin
          send_idle_pct = 63;
          recv_idle_pct = 27;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) random_request();
      // let every outstanding result come back before the next phase
      hold_until_drained();
    end

    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
